[src/mcvs_pkg.sv]
// shared types, constants and elaboration-time tables of the click voice synth
package mcvs_pkg;

   localparam int TICK_RATE_HZ     = 48000;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int ROM_BITS         = $clog2(SINE_TABLE_DEPTH);

   localparam int IDX_W             = 12;
   localparam int GAIN_TABLE_DEPTH  = 128;
   localparam int GAIN_IDX_W        = $clog2(GAIN_TABLE_DEPTH);
   localparam int MAX_LEN           = 4095;

   localparam logic [31:0]        NOISE_SEED      = 32'h13579BDF;
   localparam logic [31:0]        THIRD_OFFSET    = 32'd170891319;
   localparam logic signed [19:0] HARM3_Q15       = 20'sd5898;
   localparam logic signed [19:0] NOISE_GAIN_Q15  = 20'sd19661;
   localparam logic [15:0]        FULL_SCALE      = 16'd32767;
   localparam logic [16:0]        UNITY_GAIN      = 17'd32768;

   localparam logic [15:0] CLASS_AMP [4] = '{16'd27853, 16'd18022, 16'd9011, 16'd9011};

   typedef struct packed {
      logic       start_req;
      logic [1:0] beat_class;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               active;
   } rsp_type;

   typedef enum logic [3:0] {
      M_NONE, M_HARM, M_WAVE_ENV, M_B0, M_B2, M_A1, M_A2, M_TR,
      M_YENV, M_NGAIN, M_GAIN, M_AMP, M_ENVM, M_ENVN
   } mul_op_type;

   typedef enum logic [3:0] {
      U_NONE, U_HARM, U_SETV, U_ACC_FIRST, U_ACC_ADD, U_ACC_SUB, U_ACC_LAST,
      U_TR, U_TMP, U_NSUM, U_ENVM, U_ENVN
   } use_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK,
      ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
      ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8, ST_C9, ST_C10,
      ST_G2, ST_G3, ST_G4, ST_FIN
   } state_type;

   typedef struct packed {
      logic       load;
      logic       rom_rd;
      logic       noise_step;
      mul_op_type mul_op;
      use_op_type use_op;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic mode;
      logic out_free;
   } status_type;

   typedef logic signed [15:0] sine_rom_type [SINE_TABLE_DEPTH];
   typedef logic [16:0] gain_table_type [GAIN_TABLE_DEPTH];

   function automatic logic signed [15:0] sat16(input logic signed [41:0] v);
      if (v > 42'sd32767) return 16'sh7FFF;
      if (v < -42'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] sat16_l(input longint v);
      if (v > 64'sd32767) return 16'sh7FFF;
      if (v < -64'sd32768) return 16'sh8000;
      return 16'(v);
   endfunction

   // sine of a 32 bit phase in q30
   function automatic longint sin_q30(input logic [31:0] ph);
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      r = {34'd0, ph[29:0]};
      if (ph[30]) r = 64'h40000000 - r;
      x    = (r * 64'd1686629713) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sh40000000) sum = 64'sh40000000;
      return ph[31] ? -sum : sum;
   endfunction

   function automatic sine_rom_type build_sine();
      sine_rom_type t;
      longint       v;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         v = (sin_q30(32'(longint'(i) << (32 - ROM_BITS))) + 64'sd16384) >>> 15;
         if (v > 64'sd32767) v = 64'sd32767;
         if (v < -64'sd32767) v = -64'sd32767;
         t[i] = 16'(v);
      end
      return t;
   endfunction

   function automatic logic [31:0] phase_inc(input longint unsigned hz);
      return 32'(((hz << 32) + 64'(TICK_RATE_HZ / 2)) / 64'(TICK_RATE_HZ));
   endfunction

   function automatic logic [15:0] decay_series(input longint unsigned xq);
      longint unsigned term;
      longint          sum;
      longint          m;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int k = 1; k <= 6; k++) begin
         term = ((term * xq) >> 30) / 64'(k);
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      m = (sum + 64'sd8192) >>> 14;
      return (m > 64'sd65535) ? 16'hFFFF : 16'(m);
   endfunction

   localparam longint unsigned D_TONE  = 64'(12 * TICK_RATE_HZ);
   localparam longint unsigned D_TRANS = 64'(4 * TICK_RATE_HZ);
   localparam longint unsigned D_NOISE = 64'(8 * TICK_RATE_HZ);
   localparam logic [15:0] DEC_TONE  =
      decay_series(((64'd1000 << 30) + D_TONE / 2) / D_TONE);
   localparam logic [15:0] DEC_TRANS =
      decay_series(((64'd1000 << 30) + D_TRANS / 2) / D_TRANS);
   localparam logic [15:0] DEC_NOISE =
      decay_series(((64'd1000 << 30) + D_NOISE / 2) / D_NOISE);

   localparam int LEN_TONE_R  = TICK_RATE_HZ * 40 / 1000;
   localparam int LEN_CLICK_R = TICK_RATE_HZ * 30 / 1000;
   localparam int ATT_TONE_R  = TICK_RATE_HZ * 8 / 10000;
   localparam int ATT_CLICK_R = TICK_RATE_HZ * 4 / 10000;
   localparam int LEN_TONE  = (LEN_TONE_R > MAX_LEN) ? MAX_LEN : LEN_TONE_R;
   localparam int LEN_CLICK = (LEN_CLICK_R > MAX_LEN) ? MAX_LEN : LEN_CLICK_R;
   localparam int ATT_TONE  = (ATT_TONE_R < 1) ? 1 : ATT_TONE_R;
   localparam int ATT_CLICK = (ATT_CLICK_R < 1) ? 1 : ATT_CLICK_R;

   function automatic gain_table_type build_gain_tone();
      gain_table_type t;
      for (int i = 0; i < GAIN_TABLE_DEPTH; i++)
         t[i] = (i < ATT_TONE) ? 17'((i << 15) / ATT_TONE) : UNITY_GAIN;
      return t;
   endfunction

   function automatic gain_table_type build_gain_click();
      gain_table_type t;
      for (int i = 0; i < GAIN_TABLE_DEPTH; i++)
         t[i] = (i < ATT_CLICK) ? 17'((i << 15) / ATT_CLICK) : UNITY_GAIN;
      return t;
   endfunction

   localparam logic [31:0] INC_TONE  [4] = '{phase_inc(1500), phase_inc(1000),
                                             phase_inc(1000), phase_inc(1000)};
   localparam logic [31:0] INC_CLICK [4] = '{phase_inc(2000), phase_inc(1500),
                                             phase_inc(1500), phase_inc(1500)};

   // biquad bandpass, q2.14
   localparam logic [31:0] W_C   = phase_inc(4000);
   localparam longint      SN    = sin_q30(W_C);
   localparam longint      CS    = sin_q30(W_C + 32'h40000000);
   localparam longint      ALPHA = SN >>> 2;
   localparam longint      DEN   = (64'sd1 << 30) + ALPHA;
   localparam longint      B0_MAG = (ALPHA < 0) ? -ALPHA : ALPHA;
   localparam longint      B0_Q  = (B0_MAG * 16384 + DEN / 2) / DEN;
   localparam longint      A1_NUM = -2 * CS;
   localparam longint      A1_MAG = (A1_NUM < 0) ? -A1_NUM : A1_NUM;
   localparam longint      A1_Q  = (A1_MAG * 16384 + DEN / 2) / DEN;
   localparam longint      A2_NUM = (64'sd1 << 30) - ALPHA;
   localparam longint      A2_MAG = (A2_NUM < 0) ? -A2_NUM : A2_NUM;
   localparam longint      A2_Q  = (A2_MAG * 16384 + DEN / 2) / DEN;
   localparam logic signed [15:0] CB0 = sat16_l((ALPHA < 0) ? -B0_Q : B0_Q);
   localparam logic signed [15:0] CB2 = sat16_l(-((ALPHA < 0) ? -B0_Q : B0_Q));
   localparam logic signed [15:0] CA1 = sat16_l((A1_NUM < 0) ? -A1_Q : A1_Q);
   localparam logic signed [15:0] CA2 = sat16_l((A2_NUM < 0) ? -A2_Q : A2_Q);

endpackage

[src/mcvs_ctrl.sv]
// sequencer that steps the shared multiplier through one sample
module mcvs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mcvs_pkg::status_type status,
   output mcvs_pkg::cmd_type   cmd
);
   import mcvs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.mul_op     = M_NONE;
      cmd.use_op     = U_NONE;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.rom_rd     = 1'b1;
            cmd.noise_step = 1'b1;
            if (!status.active) state_in = ST_FIN;
            else if (status.mode) state_in = ST_C1;
            else state_in = ST_T1;
         end
         ST_T1: begin
            cmd.mul_op = M_HARM;
            state_in   = ST_T2;
         end
         ST_T2: begin
            cmd.use_op = U_HARM;
            cmd.mul_op = M_ENVM;
            state_in   = ST_T3;
         end
         ST_T3: begin
            cmd.mul_op = M_WAVE_ENV;
            cmd.use_op = U_ENVM;
            state_in   = ST_T4;
         end
         ST_T4: begin
            cmd.use_op = U_SETV;
            cmd.mul_op = M_ENVN;
            state_in   = ST_T5;
         end
         ST_T5: begin
            cmd.use_op = U_ENVN;
            cmd.mul_op = M_GAIN;
            state_in   = ST_G2;
         end
         ST_C1: begin
            cmd.mul_op = M_B0;
            state_in   = ST_C2;
         end
         ST_C2: begin
            cmd.use_op = U_ACC_FIRST;
            cmd.mul_op = M_B2;
            state_in   = ST_C3;
         end
         ST_C3: begin
            cmd.use_op = U_ACC_ADD;
            cmd.mul_op = M_A1;
            state_in   = ST_C4;
         end
         ST_C4: begin
            cmd.use_op = U_ACC_SUB;
            cmd.mul_op = M_A2;
            state_in   = ST_C5;
         end
         ST_C5: begin
            cmd.use_op = U_ACC_LAST;
            cmd.mul_op = M_TR;
            state_in   = ST_C6;
         end
         ST_C6: begin
            cmd.use_op = U_TR;
            cmd.mul_op = M_YENV;
            state_in   = ST_C7;
         end
         ST_C7: begin
            cmd.use_op = U_TMP;
            cmd.mul_op = M_ENVM;
            state_in   = ST_C8;
         end
         ST_C8: begin
            cmd.mul_op = M_NGAIN;
            cmd.use_op = U_ENVM;
            state_in   = ST_C9;
         end
         ST_C9: begin
            cmd.use_op = U_NSUM;
            cmd.mul_op = M_ENVN;
            state_in   = ST_C10;
         end
         ST_C10: begin
            cmd.use_op = U_ENVN;
            cmd.mul_op = M_GAIN;
            state_in   = ST_G2;
         end
         ST_G2: begin
            cmd.use_op = U_SETV;
            state_in   = ST_G3;
         end
         ST_G3: begin
            cmd.mul_op = M_AMP;
            state_in   = ST_G4;
         end
         ST_G4: begin
            cmd.use_op = U_SETV;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[src/mcvs_datapath.sv]
// voice state, sine rom, shared multiplier, biquad accumulator and output register
module mcvs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mcvs_pkg::cmd_type    cmd,
   output mcvs_pkg::status_type status,
   input  mcvs_pkg::req_type    req_data,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mcvs_pkg::rsp_type    rsp_data
);
   import mcvs_pkg::*;

   localparam sine_rom_type   SINE_ROM   = build_sine();
   localparam gain_table_type GAIN_TONE  = build_gain_tone();
   localparam gain_table_type GAIN_CLICK = build_gain_click();

   logic                    mode_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [31:0]             phase_ff;
   logic [15:0]             env_main_ff;
   logic [15:0]             env_noise_ff;
   logic [31:0]             noise_ff;
   logic signed [15:0]      nh1_ff, nh2_ff, fh1_ff, fh2_ff;
   logic                    active_ff;
   logic [1:0]              class_ff;
   logic signed [15:0]      rom_a_ff, rom_b_ff;
   logic signed [39:0]      prod_ff;
   logic signed [41:0]      acc_ff;
   logic signed [19:0]      val_ff, tmp_ff, tr_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;

   logic                    out_free;
   logic [31:0]             ph3;
   logic [31:0]             n1, n2, n3;
   logic signed [15:0]      x;
   logic signed [39:0]      mulr_w;
   logic signed [19:0]      mulr_v;
   logic signed [41:0]      prod_ext;
   logic signed [41:0]      acc_last;
   logic signed [41:0]      y_w;
   logic signed [15:0]      y;
   logic [39:0]             env_w;
   logic [16:0]             gain;
   logic [15:0]             dmain;
   logic [31:0]             inc;
   logic signed [19:0]      mul_a, mul_b;
   logic                    act_pre;
   logic [IDX_W-1:0]        idx_cur;
   logic [IDX_W-1:0]        len;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign status   = '{active: active_ff, mode: mode_ff, out_free: out_free};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ph3      = phase_ff + (phase_ff << 1) + THIRD_OFFSET;
   assign n1       = noise_ff ^ (noise_ff << 13);
   assign n2       = n1 ^ (n1 >> 17);
   assign n3       = n2 ^ (n2 << 5);
   assign x        = noise_ff[31:16];
   assign mulr_w   = (prod_ff + 40'sd16384) >>> 15;
   assign mulr_v   = mulr_w[19:0];
   assign prod_ext = 42'(prod_ff);
   assign acc_last = acc_ff - prod_ext;
   assign y_w      = (acc_last + 42'sd8192) >>> 14;
   assign y        = sat16(y_w);
   assign env_w    = prod_ff + 40'sd32768;
   assign dmain    = mode_ff ? DEC_TRANS : DEC_TONE;
   assign inc      = mode_ff ? INC_CLICK[class_ff] : INC_TONE[class_ff];
   assign act_pre  = req_data.start_req || active_ff;
   assign idx_cur  = req_data.start_req ? '0 : idx_ff;
   assign len      = mode_ff ? IDX_W'(LEN_CLICK) : IDX_W'(LEN_TONE);

   always_comb begin
      if (idx_ff < IDX_W'(GAIN_TABLE_DEPTH)) begin
         gain = mode_ff ? GAIN_CLICK[idx_ff[GAIN_IDX_W-1:0]]
                        : GAIN_TONE[idx_ff[GAIN_IDX_W-1:0]];
      end else begin
         gain = UNITY_GAIN;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         M_HARM: begin
            mul_a = HARM3_Q15;
            mul_b = 20'(rom_b_ff);
         end
         M_WAVE_ENV: begin
            mul_a = val_ff;
            mul_b = {4'd0, env_main_ff};
         end
         M_B0: begin
            mul_a = 20'(CB0);
            mul_b = 20'(x);
         end
         M_B2: begin
            mul_a = 20'(CB2);
            mul_b = 20'(nh2_ff);
         end
         M_A1: begin
            mul_a = 20'(CA1);
            mul_b = 20'(fh1_ff);
         end
         M_A2: begin
            mul_a = 20'(CA2);
            mul_b = 20'(fh2_ff);
         end
         M_TR: begin
            mul_a = 20'(rom_a_ff);
            mul_b = {4'd0, env_main_ff};
         end
         M_YENV: begin
            mul_a = tmp_ff;
            mul_b = {4'd0, env_noise_ff};
         end
         M_NGAIN: begin
            mul_a = tmp_ff;
            mul_b = NOISE_GAIN_Q15;
         end
         M_GAIN: begin
            mul_a = val_ff;
            mul_b = {3'd0, gain};
         end
         M_AMP: begin
            mul_a = val_ff;
            mul_b = {4'd0, CLASS_AMP[class_ff]};
         end
         M_ENVM: begin
            mul_a = {4'd0, env_main_ff};
            mul_b = {4'd0, dmain};
         end
         M_ENVN: begin
            mul_a = {4'd0, env_noise_ff};
            mul_b = {4'd0, DEC_NOISE};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         idx_ff       <= '0;
         phase_ff     <= '0;
         env_main_ff  <= FULL_SCALE;
         env_noise_ff <= FULL_SCALE;
         noise_ff     <= NOISE_SEED;
         nh1_ff       <= '0;
         nh2_ff       <= '0;
         fh1_ff       <= '0;
         fh2_ff       <= '0;
         active_ff    <= 1'b0;
         class_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         if (cmd.load) begin
            if (req_data.start_req) begin
               idx_ff       <= '0;
               phase_ff     <= '0;
               env_main_ff  <= FULL_SCALE;
               env_noise_ff <= FULL_SCALE;
               noise_ff     <= NOISE_SEED;
               nh1_ff       <= '0;
               nh2_ff       <= '0;
               fh1_ff       <= '0;
               fh2_ff       <= '0;
               class_ff     <= req_data.beat_class;
            end
            active_ff <= act_pre && (idx_cur < len);
         end
         if (cmd.noise_step && active_ff && mode_ff) noise_ff <= n3;
         if (cmd.use_op == U_ACC_LAST) begin
            nh2_ff <= nh1_ff;
            nh1_ff <= x;
            fh2_ff <= fh1_ff;
            fh1_ff <= y;
         end
         if (cmd.use_op == U_ENVM) env_main_ff <= env_w[31:16];
         if (cmd.use_op == U_ENVN) env_noise_ff <= env_w[31:16];
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            if (active_ff) begin
               phase_ff <= phase_ff + inc;
               idx_ff   <= idx_ff + 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.rom_rd) begin
         rom_a_ff <= SINE_ROM[phase_ff[31 -: ROM_BITS]];
         rom_b_ff <= SINE_ROM[ph3[31 -: ROM_BITS]];
      end
      prod_ff <= mul_a * mul_b;
      case (cmd.use_op)
         U_HARM:      val_ff <= 20'(rom_a_ff) + mulr_v;
         U_SETV:      val_ff <= mulr_v;
         U_ACC_FIRST: acc_ff <= prod_ext;
         U_ACC_ADD:   acc_ff <= acc_ff + prod_ext;
         U_ACC_SUB:   acc_ff <= acc_ff - prod_ext;
         U_ACC_LAST:  tmp_ff <= 20'(y);
         U_TR:        tr_ff  <= mulr_v;
         U_TMP:       tmp_ff <= mulr_v;
         U_NSUM:      val_ff <= tr_ff + mulr_v;
         default: begin
         end
      endcase
      if (cmd.finish) begin
         rsp_ff.sample <= active_ff ? sat16(42'(val_ff)) : '0;
         rsp_ff.active <= active_ff;
      end
   end

   a_idle_word_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.active |-> rsp_ff.sample == '0)
      else $error("idle word carries a nonzero sample");

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over an unread word");

   a_start_sounds: assert property (@(posedge clock) disable iff (reset)
      cmd.load && req_data.start_req |=> active_ff)
      else $error("start did not begin a burst");

   a_env_bounded: assert property (@(posedge clock) disable iff (reset)
      env_main_ff <= FULL_SCALE && env_noise_ff <= FULL_SCALE)
      else $error("envelope above full scale");

endmodule

[src/metronome_click_voice_synth_unit.sv]
// top level of the metronome click voice synth
//
//   channel  dir  handshake              word
//   req      in   req_valid/req_ready    start_req, beat_class
//   rsp      out  rsp_valid/rsp_ready    sample, active
//   csr      in   csr_wr_en              voice_mode
//
// one word at a time; the click voice takes more sequencer steps than the tone voice
// and an idle tick the fewest, set by the single shared multiplier
// reset is synchronous and restores the burst state and voice_mode
// a held result stalls the sequencer in its last step until rsp_ready
module metronome_click_voice_synth_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mcvs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcvs_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import mcvs_pkg::*;

   cmd_type    cmd;
   status_type status;

   mcvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcvs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
